// ===== hdl/salru_pkg.sv =====
package salru_pkg;

   localparam int MAX_WAYS   = 4;
   localparam int NUM_BLOCKS = 256;
   localparam int AGE_WIDTH  = 8;

   localparam int MAX_WAY_LOG2 = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
   localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int BLK_W        = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   localparam int ADDR_W    = 32;
   localparam int TAG_W     = 32;
   localparam int IN_BLK_W  = 8;
   localparam int IN_AGE_W  = 8;
   localparam int OUT_BLK_W = 8;
   localparam int OUT_AGE_W = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam int WL_W       = 2;
   localparam int FIELD_W    = 4;

   localparam logic [WL_W-1:0]    WAY_LOG2_RST    = 2'd0;
   localparam logic [FIELD_W-1:0] INDEX_BITS_RST  = 4'd6;
   localparam logic [FIELD_W-1:0] OFFSET_BITS_RST = 4'd4;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_WRITE  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WAY_LOG2    = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_OFFSET_BITS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      SC_IDLE,
      SC_SCAN,
      SC_DONE
   } scan_state_type;

   typedef struct packed {
      logic                mode;
      logic [ADDR_W-1:0]   address;
      logic [IN_BLK_W-1:0] entry_block;
      logic [TAG_W-1:0]    entry_tag;
      logic                entry_valid;
      logic [IN_AGE_W-1:0] entry_age;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [OUT_BLK_W-1:0] block_number;
      logic [OUT_AGE_W-1:0] age_value;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [AGE_WIDTH-1:0] age;
      logic [TAG_W-1:0]     tag;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [BLK_W-1:0] addr;
      entry_type        entry;
   } wr_req_type;

   typedef struct packed {
      logic             en;
      logic [BLK_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [TAG_W-1:0] tmask;
      logic [BLK_W-1:0] base;
      logic [WAY_W-1:0] last_way;
      logic             multi;
   } scan_cmd_type;

endpackage

// ===== hdl/salru_store.sv =====
module salru_store (
   input  logic                  clock,
   input  logic                  reset,
   input  salru_pkg::wr_req_type wr,
   input  salru_pkg::rd_req_type rd,
   output salru_pkg::entry_type  rd_entry
);

   salru_pkg::entry_type mem [salru_pkg::NUM_BLOCKS];
   salru_pkg::entry_type rd_data_ff;
   logic [salru_pkg::NUM_BLOCKS-1:0] written_ff;
   logic rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            written_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            rd_written_ff <= written_ff[rd.addr];
         end
      end
   end

   // An entry never written reads as invalid with age zero.
   always_comb begin
      rd_entry.valid = rd_written_ff & rd_data_ff.valid;
      rd_entry.age   = rd_written_ff ? rd_data_ff.age : '0;
      rd_entry.tag   = rd_data_ff.tag;
   end

endmodule

// ===== hdl/salru_scan.sv =====
module salru_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  salru_pkg::scan_cmd_type cmd,
   input  salru_pkg::entry_type    rd_entry,
   input  logic                    out_free,
   output salru_pkg::rd_req_type   rd,
   output logic                    idle,
   output logic                    done,
   output salru_pkg::rsp_type      result
);

   salru_pkg::scan_state_type state_ff, state_in;
   salru_pkg::scan_cmd_type   cmd_ff;
   logic [salru_pkg::WAY_W-1:0]     iss_ff;
   logic [salru_pkg::WAY_W-1:0]     ev_way_ff;
   logic                            iss_done_ff;
   logic                            ev_valid_ff;
   logic                            res_hit_ff;
   logic [salru_pkg::BLK_W-1:0]     res_blk_ff;
   logic [salru_pkg::AGE_WIDTH-1:0] res_age_ff;

   logic [salru_pkg::BLK_W-1:0] ev_blk;
   logic ev_hit;
   logic ev_last;
   logic ev_older;

   always_comb begin
      ev_blk   = cmd_ff.base + salru_pkg::BLK_W'(ev_way_ff);
      ev_hit   = ev_valid_ff && rd_entry.valid &&
                 ((rd_entry.tag & cmd_ff.tmask) == cmd_ff.tag);
      ev_last  = ev_valid_ff && (ev_way_ff == cmd_ff.last_way);
      ev_older = cmd_ff.multi && (rd_entry.age > res_age_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         salru_pkg::SC_IDLE: begin
            if (start) begin
               state_in = salru_pkg::SC_SCAN;
            end
         end
         salru_pkg::SC_SCAN: begin
            if (ev_hit || ev_last) begin
               state_in = salru_pkg::SC_DONE;
            end
         end
         salru_pkg::SC_DONE: begin
            if (out_free) begin
               state_in = salru_pkg::SC_IDLE;
            end
         end
         default: begin
            state_in = salru_pkg::SC_IDLE;
         end
      endcase
   end

   always_comb begin
      rd.en   = (state_ff == salru_pkg::SC_SCAN) && !iss_done_ff;
      rd.addr = cmd_ff.base + salru_pkg::BLK_W'(iss_ff);
      idle    = (state_ff == salru_pkg::SC_IDLE);
      done    = (state_ff == salru_pkg::SC_DONE);
      result.hit          = res_hit_ff;
      result.block_number = salru_pkg::OUT_BLK_W'(res_blk_ff);
      result.age_value    = salru_pkg::OUT_AGE_W'(res_age_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= salru_pkg::SC_IDLE;
         ev_valid_ff <= 1'b0;
         iss_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ev_valid_ff <= rd.en;
         if (start) begin
            iss_done_ff <= 1'b0;
         end else if (rd.en && (iss_ff == cmd_ff.last_way)) begin
            iss_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ev_way_ff <= iss_ff;
      if (start) begin
         cmd_ff     <= cmd;
         iss_ff     <= '0;
         res_hit_ff <= 1'b0;
         res_blk_ff <= cmd.base;
         res_age_ff <= '0;
      end else begin
         if (rd.en) begin
            iss_ff <= iss_ff + salru_pkg::WAY_W'(1);
         end
         if ((state_ff == salru_pkg::SC_SCAN) && ev_valid_ff) begin
            if (ev_hit) begin
               res_hit_ff <= 1'b1;
               res_blk_ff <= ev_blk;
               res_age_ff <= rd_entry.age;
            end else if (ev_older) begin
               res_blk_ff <= ev_blk;
               res_age_ff <= rd_entry.age;
            end
         end
      end
   end

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == salru_pkg::SC_IDLE))
      else $error("Scan started while busy.");

   a_no_eval_in_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == salru_pkg::SC_IDLE) |-> !ev_valid_ff)
      else $error("Read data evaluated while idle.");

   a_eval_in_set: assert property (@(posedge clock) disable iff (reset)
      ev_valid_ff |-> (ev_way_ff <= cmd_ff.last_way))
      else $error("Way read beyond the set.");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == salru_pkg::SC_DONE) && $past(state_ff == salru_pkg::SC_DONE)) |->
      ($stable(res_hit_ff) && $stable(res_blk_ff) && $stable(res_age_ff)))
      else $error("Finished result changed while waiting.");

endmodule

// ===== hdl/set_assoc_lookup_lru_victim.sv =====
// Set-associative tag lookup with least-recently-used victim choice.
// The req_ channel carries one beat per item. A write beat loads the tag,
// valid mark and age of one block into the tag memory and gives no result.
// A lookup beat splits its address by the configured offset and index
// sizes, reads the ways of the selected set one per cycle from the tag
// memory's read port, and returns one rsp_ beat with the hit block, or on
// a miss the oldest way of the set (first way on ties).
// A lookup's result goes to the output register once the last way of the
// set has been read and checked, or sooner on an early hit; the next beat
// is taken only after the result has moved into that register. The way
// reads set the pace.
// The csr_ port is always ready; write it only while the block is idle.
// Reset restores the register defaults and marks every entry unwritten,
// so it reads as invalid with age zero; no clearing pass is needed.
// When rsp_stall is high the result beat holds in the output register,
// and the block still accepts one more item and works it until its own
// result is ready.
module set_assoc_lookup_lru_victim (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  salru_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output salru_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [salru_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [salru_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [salru_pkg::WL_W-1:0]    way_log2_ff;
   logic [salru_pkg::FIELD_W-1:0] index_bits_ff;
   logic [salru_pkg::FIELD_W-1:0] offset_bits_ff;

   logic                 rsp_valid_ff;
   salru_pkg::rsp_type   rsp_data_ff;

   salru_pkg::wr_req_type   wr;
   salru_pkg::rd_req_type   rd;
   salru_pkg::entry_type    rd_entry;
   salru_pkg::scan_cmd_type cmd;
   salru_pkg::rsp_type      scan_result;

   logic req_accept;
   logic start;
   logic scan_idle;
   logic scan_done;
   logic out_free;
   logic in_range;
   logic [salru_pkg::WL_W-1:0]   wl_eff;
   logic [4:0]                   low;
   logic [salru_pkg::ADDR_W-1:0] set_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         way_log2_ff    <= salru_pkg::WAY_LOG2_RST;
         index_bits_ff  <= salru_pkg::INDEX_BITS_RST;
         offset_bits_ff <= salru_pkg::OFFSET_BITS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            salru_pkg::CSR_WAY_LOG2: begin
               way_log2_ff <= csr_data[salru_pkg::WL_W-1:0];
            end
            salru_pkg::CSR_INDEX_BITS: begin
               index_bits_ff <= csr_data[salru_pkg::FIELD_W-1:0];
            end
            salru_pkg::CSR_OFFSET_BITS: begin
               offset_bits_ff <= csr_data[salru_pkg::FIELD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_stall  = !scan_idle;
   assign req_accept = req_valid && !req_stall;
   assign start      = req_accept && (req_data.mode == salru_pkg::MODE_LOOKUP);

   always_comb begin
      in_range = 32'(req_data.entry_block) < 32'(salru_pkg::NUM_BLOCKS);
      wr.en    = req_accept && (req_data.mode == salru_pkg::MODE_WRITE) && in_range;
      wr.addr  = salru_pkg::BLK_W'(req_data.entry_block);
      wr.entry.valid = req_data.entry_valid;
      wr.entry.age   = salru_pkg::AGE_WIDTH'(req_data.entry_age);
      wr.entry.tag   = req_data.entry_tag;
   end

   always_comb begin
      wl_eff = (32'(way_log2_ff) > 32'(salru_pkg::MAX_WAY_LOG2)) ?
               salru_pkg::WL_W'(salru_pkg::MAX_WAY_LOG2) : way_log2_ff;
      low      = 5'(offset_bits_ff) + 5'(index_bits_ff);
      set_full = (req_data.address >> offset_bits_ff) &
                 ~({salru_pkg::ADDR_W{1'b1}} << index_bits_ff);
      cmd.base     = salru_pkg::BLK_W'(set_full << wl_eff);
      cmd.tag      = req_data.address >> low;
      cmd.tmask    = {salru_pkg::TAG_W{1'b1}} >> low;
      cmd.last_way = salru_pkg::WAY_W'((32'd1 << wl_eff) - 32'd1);
      cmd.multi    = (wl_eff != '0);
   end

   salru_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd       (rd),
      .rd_entry (rd_entry)
   );

   salru_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .cmd      (cmd),
      .rd_entry (rd_entry),
      .out_free (out_free),
      .rd       (rd),
      .idle     (scan_idle),
      .done     (scan_done),
      .result   (scan_result)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= scan_done;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_done && out_free) begin
         rsp_data_ff <= scan_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sim/set_assoc_lookup_lru_victim_test.sv =====
`timescale 1ns / 1ps

module set_assoc_lookup_lru_victim_test;

   localparam int CLOCK_HALF    = 6;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int REPORT_LIMIT  = 10;
   localparam int CHUNK_BEATS   = 125;
   localparam int TIMEOUT_NS    = 12_000_000;
   localparam logic [salru_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                             clock     = 1'b0;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   salru_pkg::req_type               req_data  = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   salru_pkg::rsp_type               rsp_data;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [salru_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [salru_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   int unsigned                     way_log2_cfg;
   int unsigned                     index_cfg;
   int unsigned                     offset_cfg;
   logic [salru_pkg::TAG_W-1:0]     tag_shadow [salru_pkg::NUM_BLOCKS];
   logic                            valid_shadow [salru_pkg::NUM_BLOCKS];
   logic [salru_pkg::AGE_WIDTH-1:0] age_shadow [salru_pkg::NUM_BLOCKS];
   salru_pkg::rsp_type              pending_results [$];

   int fail_count    = 0;
   int beat_count    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   int hold_left     = 0;

   set_assoc_lookup_lru_victim u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   function automatic int unsigned way_count();
      return ((1 << way_log2_cfg) > salru_pkg::MAX_WAYS) ? salru_pkg::MAX_WAYS
                                                          : (1 << way_log2_cfg);
   endfunction

   function automatic int unsigned set_base(logic [salru_pkg::ADDR_W-1:0] addr);
      return ((addr >> offset_cfg) & ((32'd1 << index_cfg) - 1)) * way_count();
   endfunction

   function automatic logic [salru_pkg::TAG_W-1:0] tag_mask();
      int unsigned low_bits;
      low_bits = offset_cfg + index_cfg;
      return (low_bits >= 32) ? '0 : salru_pkg::TAG_W'((64'd1 << (32 - low_bits)) - 1);
   endfunction

   function automatic logic [salru_pkg::TAG_W-1:0] addr_tag(
         logic [salru_pkg::ADDR_W-1:0] addr);
      return salru_pkg::TAG_W'(64'(addr) >> (offset_cfg + index_cfg));
   endfunction

   function automatic salru_pkg::rsp_type predict_lookup(
         logic [salru_pkg::ADDR_W-1:0] addr);
      int unsigned                     base;
      int unsigned                     blk;
      int unsigned                     victim;
      logic [salru_pkg::AGE_WIDTH-1:0] oldest;
      logic [salru_pkg::TAG_W-1:0]     tag;
      logic [salru_pkg::TAG_W-1:0]     mask;
      salru_pkg::rsp_type              res;
      base   = set_base(addr);
      tag    = addr_tag(addr);
      mask   = tag_mask();
      victim = base % salru_pkg::NUM_BLOCKS;
      oldest = '0;
      for (int w = 0; w < way_count(); w++) begin
         blk = (base + w) % salru_pkg::NUM_BLOCKS;
         if (valid_shadow[blk] && (tag_shadow[blk] & mask) == tag) begin
            res.hit          = 1'b1;
            res.block_number = salru_pkg::OUT_BLK_W'(blk);
            res.age_value    = salru_pkg::OUT_AGE_W'(age_shadow[blk]);
            return res;
         end
         if (way_count() > 1 && age_shadow[blk] > oldest) begin
            oldest = age_shadow[blk];
            victim = blk;
         end
      end
      res.hit          = 1'b0;
      res.block_number = salru_pkg::OUT_BLK_W'(victim);
      res.age_value    = salru_pkg::OUT_AGE_W'(oldest);
      return res;
   endfunction

   function automatic void model_beat(salru_pkg::req_type item);
      if (item.mode == salru_pkg::MODE_WRITE) begin
         if (32'(item.entry_block) < salru_pkg::NUM_BLOCKS) begin
            tag_shadow[item.entry_block]   = item.entry_tag;
            valid_shadow[item.entry_block] = item.entry_valid;
            age_shadow[item.entry_block]   = item.entry_age;
         end
      end else begin
         pending_results.push_back(predict_lookup(item.address));
      end
   endfunction

   function automatic salru_pkg::req_type lookup_beat(logic [salru_pkg::ADDR_W-1:0] addr);
      salru_pkg::req_type item;
      item.mode        = salru_pkg::MODE_LOOKUP;
      item.address     = addr;
      item.entry_block = salru_pkg::IN_BLK_W'($urandom);
      item.entry_tag   = $urandom;
      item.entry_valid = 1'($urandom);
      item.entry_age   = salru_pkg::IN_AGE_W'($urandom);
      return item;
   endfunction

   function automatic salru_pkg::req_type write_beat(
         logic [salru_pkg::IN_BLK_W-1:0] blk, logic [salru_pkg::TAG_W-1:0] tag,
         logic valid, logic [salru_pkg::IN_AGE_W-1:0] age);
      salru_pkg::req_type item;
      item.mode        = salru_pkg::MODE_WRITE;
      item.address     = $urandom;
      item.entry_block = blk;
      item.entry_tag   = tag;
      item.entry_valid = valid;
      item.entry_age   = age;
      return item;
   endfunction

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      salru_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result hit=%0d block=%0d age=%0d",
                                   rsp_data.hit, rsp_data.block_number, rsp_data.age_value));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.block_number !== want.block_number ||
                rsp_data.age_value !== want.age_value) begin
               note_failure($sformatf(
                  "expected hit=%0d block=%0d age=%0d, got hit=%0d block=%0d age=%0d",
                  want.hit, want.block_number, want.age_value,
                  rsp_data.hit, rsp_data.block_number, rsp_data.age_value));
            end
         end
      end
   end

   task automatic send_item(salru_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      model_beat(item);
      beat_count++;
   endtask

   // A write beat gives no result; settle waits for every pending lookup
   // result and then lets the bench idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [salru_pkg::CSR_IDX_W-1:0] idx,
                            logic [salru_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         salru_pkg::CSR_WAY_LOG2:    way_log2_cfg = 32'(val[salru_pkg::WL_W-1:0]);
         salru_pkg::CSR_INDEX_BITS:  index_cfg    = 32'(val);
         salru_pkg::CSR_OFFSET_BITS: offset_cfg   = 32'(val);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(logic [salru_pkg::CSR_DATA_W-1:0] ways_val,
                             logic [salru_pkg::CSR_DATA_W-1:0] index_val,
                             logic [salru_pkg::CSR_DATA_W-1:0] offset_val);
      settle();
      csr_write(salru_pkg::CSR_WAY_LOG2, ways_val);
      csr_write(salru_pkg::CSR_INDEX_BITS, index_val);
      csr_write(salru_pkg::CSR_OFFSET_BITS, offset_val);
   endtask

   // Fill some ways of one set, sometimes with the looked-up tag, then look up.
   task automatic exercise_set();
      logic [salru_pkg::ADDR_W-1:0]    addr;
      logic [salru_pkg::TAG_W-1:0]     tag;
      logic [salru_pkg::TAG_W-1:0]     mask;
      logic [salru_pkg::AGE_WIDTH-1:0] age;
      int unsigned                     base;
      int unsigned                     ways;
      int unsigned                     blk;
      addr = $urandom;
      base = set_base(addr);
      ways = way_count();
      tag  = addr_tag(addr);
      mask = tag_mask();
      repeat ($urandom_range(ways)) begin
         blk = (base + $urandom_range(ways - 1)) % salru_pkg::NUM_BLOCKS;
         case ($urandom_range(3))
            0:       age = '0;
            1:       age = '1;
            2:       age = salru_pkg::AGE_WIDTH'($urandom_range(3));
            default: age = salru_pkg::AGE_WIDTH'($urandom);
         endcase
         send_item(write_beat(salru_pkg::IN_BLK_W'(blk),
                              ($urandom_range(1) ? tag : $urandom) | ($urandom & ~mask),
                              $urandom_range(9) != 0, age));
      end
      send_item(lookup_beat(addr));
   endtask

   task automatic test_reset_defaults();
      send_item(lookup_beat(32'h0000_0000));
      send_item(lookup_beat(32'hFFFF_FFFF));
   endtask

   task automatic test_direct_mapped();
      send_item(write_beat(8'd5, 32'hFFFF_FFFF, 1'b1, 8'd200));
      send_item(lookup_beat(32'hFFFF_FC5F));
      send_item(lookup_beat(32'h0000_0050));
      send_item(write_beat(8'd6, 32'h0000_0000, 1'b0, 8'd255));
      send_item(lookup_beat(32'h0000_0060));
   endtask

   task automatic test_four_way();
      set_config(4'd2, 4'd2, 4'd0);
      send_item(write_beat(8'd4, 32'd10, 1'b1, 8'd3));
      send_item(write_beat(8'd5, 32'd20, 1'b0, 8'd9));
      send_item(write_beat(8'd6, 32'd20, 1'b1, 8'd9));
      send_item(write_beat(8'd7, 32'd20, 1'b1, 8'd1));
      send_item(lookup_beat(32'd81));
      send_item(lookup_beat(32'd397));
      send_item(lookup_beat(32'd2));
   endtask

   task automatic test_way_saturation();
      set_config(4'd3, 4'd2, 4'd0);
      send_item(lookup_beat(32'd81));
      settle();
      csr_write(CSR_SPARE, 4'hF);
      csr_write(salru_pkg::CSR_WAY_LOG2, 4'b1110);
      send_item(lookup_beat(32'd81));
   endtask

   task automatic test_field_extremes();
      set_config(4'd2, 4'd15, 4'd15);
      send_item(write_beat(8'd253, 32'hFFFF_FFFF, 1'b1, 8'd255));
      send_item(lookup_beat(32'hFFFF_FFFF));
      set_config(4'd2, 4'd0, 4'd0);
      send_item(lookup_beat(32'h1234_5678));
   endtask

   task automatic test_random_traffic(int chunks);
      logic [salru_pkg::CSR_DATA_W-1:0] index_val;
      logic [salru_pkg::CSR_DATA_W-1:0] offset_val;
      int                               chunk_end;
      repeat (chunks) begin
         index_val  = ($urandom_range(3) == 0) ?
                      (($urandom_range(1) != 0) ? 4'd0 : 4'd15) :
                      salru_pkg::CSR_DATA_W'($urandom_range(8));
         offset_val = ($urandom_range(3) == 0) ?
                      (($urandom_range(1) != 0) ? 4'd0 : 4'd15) :
                      salru_pkg::CSR_DATA_W'($urandom_range(12));
         set_config(salru_pkg::CSR_DATA_W'($urandom), index_val, offset_val);
         chunk_end = beat_count + CHUNK_BEATS;
         while (beat_count < chunk_end) begin
            if ($urandom_range(9) < 7) begin
               exercise_set();
            end else if ($urandom_range(1)) begin
               send_item(write_beat(salru_pkg::IN_BLK_W'($urandom), $urandom,
                                    1'($urandom), salru_pkg::IN_AGE_W'($urandom)));
            end else begin
               send_item(lookup_beat($urandom));
            end
         end
      end
   endtask

   task automatic test_backpressure();
      settle();
      hold_request = 400;
      repeat (20) exercise_set();
   endtask

   initial begin
      salru_pkg::rsp_type lost;
      for (int b = 0; b < salru_pkg::NUM_BLOCKS; b++) begin
         tag_shadow[b]   = '0;
         valid_shadow[b] = 1'b0;
         age_shadow[b]   = '0;
      end
      way_log2_cfg  = 32'(salru_pkg::WAY_LOG2_RST);
      index_cfg     = 32'(salru_pkg::INDEX_BITS_RST);
      offset_cfg    = 32'(salru_pkg::OFFSET_BITS_RST);
      send_idle_pct = 14;
      recv_idle_pct = 68;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_direct_mapped();
      test_four_way();
      test_way_saturation();
      test_field_extremes();
      test_random_traffic(5);
      send_idle_pct = 68;
      recv_idle_pct = 14;
      test_random_traffic(5);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(5);
      test_backpressure();

      req_valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && pending_results.size() != 0; n++) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (pending_results.size() != 0) begin
         lost = pending_results.pop_front();
         note_failure($sformatf("result never arrived, block=%0d", lost.block_number));
      end
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
